/* hdl/gcp_pkg.sv */
// gcp_pkg: shared constants and helpers for the gpu command port
`timescale 1ns / 1ps
`default_nettype none
package gcp_pkg;

  localparam int VRAM_WIDTH_DEF  = 1024;
  localparam int VRAM_HEIGHT_DEF = 512;

  localparam logic [1:0] OP_GP0  = 2'd0;
  localparam logic [1:0] OP_GP1  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] CMD_RECT     = 8'h68;
  localparam logic [7:0] CMD_CPU2VRAM = 8'hA0;
  localparam logic [7:0] CMD_VRAM2CPU = 8'hC0;
  localparam logic [7:0] GP1_RESET    = 8'h00;
  localparam logic [7:0] GP1_INFO     = 8'h10;

  localparam logic [2:0]  INFO_SEL = 3'h7;
  localparam logic [31:0] INFO_VAL = 32'h0000_0002;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_RECT = 2'd1;
  localparam logic [1:0] PEND_C2V  = 2'd2;
  localparam logic [1:0] PEND_V2C  = 2'd3;

  localparam logic [31:0] ST_RESET   = 32'h1480_2000;
  localparam int          ST_READY   = 26;
  localparam int          ST_READOUT = 27;

  localparam logic [9:0]  X_MASK     = 10'h3FF;
  localparam logic [23:0] COLOR_MASK = 24'hFF_FFFF;

  // remainder of a small value (below 32 times m) by restoring subtraction
  function automatic logic [12:0] mod_small(logic [12:0] v, logic [12:0] m);
    logic [17:0] acc;
    logic [17:0] sh;
    acc = {5'd0, v};
    for (int k = 4; k >= 0; k--) begin
      sh = {5'd0, m} << k;
      if (acc >= sh) acc = acc - sh;
    end
    return acc[12:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/gcp_ram.sv */
// gcp_ram: generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* hdl/gpu_command_port_vram_transfer.sv */
// gpu_command_port_vram_transfer: gp0/gp1 command port with a 16-bit pixel vram
`timescale 1ns / 1ps
`default_nettype none
// Every accepted item gives one result item. Commands, parameters, GP1 words
// and reads outside a readback finish in the cycle they are accepted. A
// CPU-to-VRAM data word also passes through S_WR1, and a readback GPUREAD
// through S_RD1 and S_RD2, since each touches two pixels through the single
// port of the vram, whose read data is registered. The final parameter of a copy
// adds a setup state (origin wrap and word count) before the next item is taken. A
// result waiting in the output register holds off new items only while it is stalled.
module gpu_command_port_vram_transfer #(
  parameter int VRAM_WIDTH  = gcp_pkg::VRAM_WIDTH_DEF,
  parameter int VRAM_HEIGHT = gcp_pkg::VRAM_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_word,
  output logic [31:0]      out_status_word,
  output logic             out_draw_valid,
  output logic [15:0]      out_draw_x,
  output logic [15:0]      out_draw_y,
  output logic [23:0]      out_draw_color
);

  localparam int DEPTH = VRAM_WIDTH * VRAM_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(VRAM_WIDTH);
  localparam int YW    = $clog2(VRAM_HEIGHT);
  localparam logic [AW-1:0] W_A = AW'(VRAM_WIDTH);
  localparam logic [XW-1:0] X_LAST = XW'(VRAM_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(VRAM_HEIGHT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR1   = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;

  typedef struct packed {
    logic [10:0]   x;
    logic [XW-1:0] mx;
    logic [YW-1:0] my;
  } walk_t;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] status_r, status_nxt;
  logic [31:0] latch_r, latch_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  pleft_r, pleft_nxt;
  logic [31:0] p0_r, p0_nxt;
  logic [31:0] p1_r, p1_nxt;
  logic        copy_r, copy_nxt;
  walk_t       walk_r, walk_nxt;
  logic [9:0]  x_org_r, x_org_nxt;
  logic [XW-1:0] mx_org_r, mx_org_nxt;
  logic [10:0] x_end_r, x_end_nxt;
  logic [18:0] words_r, words_nxt;
  logic [23:0] color_r, color_nxt;
  logic [15:0] hold_r, hold_nxt;

  logic        ov_r, ov_nxt;
  logic [31:0] o_read_r, o_read_nxt;
  logic [31:0] o_stat_r, o_stat_nxt;
  logic        o_dv_r, o_dv_nxt;
  logic [15:0] o_dx_r, o_dx_nxt;
  logic [15:0] o_dy_r, o_dy_nxt;
  logic [23:0] o_dc_r, o_dc_nxt;

  logic          ram_we;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;
  logic [AW-1:0] ram_addr;

  function automatic walk_t walk_adv(walk_t w, logic [9:0] org, logic [XW-1:0] morg,
                                     logic [10:0] xend);
    walk_t       r;
    logic [10:0] nx;
    nx = w.x + 11'd1;
    r  = w;
    if (nx >= xend) begin
      r.x  = {1'b0, org};
      r.mx = morg;
      r.my = (w.my == Y_LAST) ? '0 : w.my + YW'(1);
    end else begin
      r.x  = nx;
      r.mx = (w.mx == X_LAST) ? '0 : w.mx + XW'(1);
    end
    return r;
  endfunction

  assign ram_addr = AW'(walk_r.my) * W_A + AW'(walk_r.mx);
  assign in_stall = (st_r != S_IDLE) || (ov_r && out_stall);

  gcp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic        acc;
    logic        ready;
    logic        readout;
    logic [7:0]  cmd;
    logic        done;
    logic [9:0]  wm1;
    logic [8:0]  hm1;
    logic [10:0] wpix;
    logic [9:0]  hpix;
    logic [19:0] area;
    walk_t       clr;

    st_nxt = st_r; status_nxt = status_r; latch_nxt = latch_r;
    pend_nxt = pend_r; pleft_nxt = pleft_r; p0_nxt = p0_r; p1_nxt = p1_r;
    copy_nxt = copy_r; walk_nxt = walk_r; x_org_nxt = x_org_r;
    mx_org_nxt = mx_org_r; x_end_nxt = x_end_r; words_nxt = words_r;
    color_nxt = color_r; hold_nxt = hold_r;
    ov_nxt = ov_r && out_stall;
    o_read_nxt = o_read_r; o_stat_nxt = o_stat_r; o_dv_nxt = o_dv_r;
    o_dx_nxt = o_dx_r; o_dy_nxt = o_dy_r; o_dc_nxt = o_dc_r;
    ram_we = 1'b0; ram_wdata = in_data_word[15:0];

    acc     = in_valid && !in_stall;
    ready   = status_r[gcp_pkg::ST_READY];
    readout = status_r[gcp_pkg::ST_READOUT];
    cmd     = in_data_word[31:24];
    done    = 1'b0;
    clr     = '0;
    // size fields are taken mod their range, so a zero field means the full range
    wm1     = p1_r[9:0] - 10'd1;
    hm1     = p1_r[24:16] - 9'd1;
    wpix    = {1'b0, wm1} + 11'd1;
    hpix    = {1'b0, hm1} + 10'd1;
    area    = '0;

    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          done = 1'b1;
          o_dv_nxt = 1'b0; o_dx_nxt = '0; o_dy_nxt = '0; o_dc_nxt = '0;
          if (in_operation == gcp_pkg::OP_GP0) begin
            if (ready) begin
              if (cmd == gcp_pkg::CMD_RECT) begin
                pend_nxt = gcp_pkg::PEND_RECT; pleft_nxt = 2'd1;
                color_nxt = in_data_word[23:0] & gcp_pkg::COLOR_MASK;
                status_nxt[gcp_pkg::ST_READY] = 1'b0;
              end else if (cmd == gcp_pkg::CMD_CPU2VRAM || cmd == gcp_pkg::CMD_VRAM2CPU) begin
                pend_nxt = (cmd == gcp_pkg::CMD_CPU2VRAM) ? gcp_pkg::PEND_C2V
                                                          : gcp_pkg::PEND_V2C;
                pleft_nxt = 2'd2;
                status_nxt[gcp_pkg::ST_READY] = 1'b0;
              end
            end else if (pend_r != gcp_pkg::PEND_NONE && pleft_r != 2'd0) begin
              pleft_nxt = pleft_r - 2'd1;
              if (pend_r == gcp_pkg::PEND_RECT || pleft_r == 2'd2) p0_nxt = in_data_word;
              else p1_nxt = in_data_word;
              if (pleft_r == 2'd1) begin
                pend_nxt = gcp_pkg::PEND_NONE;
                if (pend_r == gcp_pkg::PEND_RECT) begin
                  o_dv_nxt = 1'b1;
                  o_dx_nxt = in_data_word[15:0];
                  o_dy_nxt = in_data_word[31:16];
                  o_dc_nxt = color_r;
                  status_nxt[gcp_pkg::ST_READY] = 1'b1;
                end else begin
                  // walk registers are loaded in the setup cycle
                  st_nxt = S_SETUP;
                  copy_nxt = (pend_r == gcp_pkg::PEND_C2V);
                  if (pend_r == gcp_pkg::PEND_V2C) status_nxt[gcp_pkg::ST_READOUT] = 1'b1;
                end
              end
            end else if (!readout && copy_r) begin
              ram_we = 1'b1;
              hold_nxt = in_data_word[31:16];
              walk_nxt = walk_adv(walk_r, x_org_r, mx_org_r, x_end_r);
              st_nxt = S_WR1;
              done = 1'b0;
            end
          end else if (in_operation == gcp_pkg::OP_GP1) begin
            if (cmd == gcp_pkg::GP1_RESET) status_nxt = gcp_pkg::ST_RESET;
            else if (cmd == gcp_pkg::GP1_INFO && in_data_word[2:0] == gcp_pkg::INFO_SEL)
              latch_nxt = gcp_pkg::INFO_VAL;
          end else if (in_operation == gcp_pkg::OP_READ && readout) begin
            walk_nxt = walk_adv(walk_r, x_org_r, mx_org_r, x_end_r);
            st_nxt = S_RD1;
            done = 1'b0;
          end
        end
      end
      S_WR1: begin
        ram_we = 1'b1;
        ram_wdata = hold_r;
        walk_nxt = walk_adv(walk_r, x_org_r, mx_org_r, x_end_r);
        st_nxt = S_IDLE;
        done = 1'b1;
        if (words_r <= 19'd1) begin
          copy_nxt = 1'b0;
          walk_nxt = clr; x_org_nxt = '0; mx_org_nxt = '0; x_end_nxt = '0; words_nxt = '0;
          status_nxt[gcp_pkg::ST_READY] = 1'b1;
        end else begin
          words_nxt = words_r - 19'd1;
        end
      end
      S_RD1: begin
        // first pixel arrives while the second is addressed
        hold_nxt = ram_rdata;
        walk_nxt = walk_adv(walk_r, x_org_r, mx_org_r, x_end_r);
        st_nxt = S_RD2;
      end
      S_RD2: begin
        latch_nxt = {hold_r, ram_rdata};
        st_nxt = S_IDLE;
        done = 1'b1;
        if (words_r <= 19'd1) begin
          status_nxt[gcp_pkg::ST_READOUT] = 1'b0;
          status_nxt[gcp_pkg::ST_READY] = 1'b1;
          walk_nxt = clr; x_org_nxt = '0; mx_org_nxt = '0; x_end_nxt = '0; words_nxt = '0;
        end else begin
          words_nxt = words_r - 19'd1;
        end
      end
      S_SETUP: begin
        area = 20'(wpix) * 20'(hpix) + 20'd1;
        x_org_nxt  = p0_r[9:0] & gcp_pkg::X_MASK;
        x_end_nxt  = {1'b0, p0_r[9:0]} + wpix;
        words_nxt  = area[19:1];
        mx_org_nxt = XW'(gcp_pkg::mod_small({3'd0, p0_r[9:0]}, 13'(VRAM_WIDTH)));
        walk_nxt.x  = {1'b0, p0_r[9:0]};
        walk_nxt.mx = XW'(gcp_pkg::mod_small({3'd0, p0_r[9:0]}, 13'(VRAM_WIDTH)));
        walk_nxt.my = YW'(gcp_pkg::mod_small({4'd0, p0_r[24:16]}, 13'(VRAM_HEIGHT)));
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    if (done) begin
      ov_nxt = 1'b1;
      o_read_nxt = latch_nxt;
      o_stat_nxt = status_nxt;
      if (st_r != S_IDLE) begin
        o_dv_nxt = 1'b0; o_dx_nxt = '0; o_dy_nxt = '0; o_dc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      status_r <= gcp_pkg::ST_RESET;
      latch_r <= '0;
      pend_r <= gcp_pkg::PEND_NONE;
      pleft_r <= '0;
      p0_r <= '0;
      p1_r <= '0;
      copy_r <= 1'b0;
      walk_r <= '0;
      x_org_r <= '0;
      mx_org_r <= '0;
      x_end_r <= '0;
      words_r <= '0;
      color_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      status_r <= status_nxt;
      latch_r <= latch_nxt;
      pend_r <= pend_nxt;
      pleft_r <= pleft_nxt;
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      copy_r <= copy_nxt;
      walk_r <= walk_nxt;
      x_org_r <= x_org_nxt;
      mx_org_r <= mx_org_nxt;
      x_end_r <= x_end_nxt;
      words_r <= words_nxt;
      color_r <= color_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    o_read_r <= o_read_nxt;
    o_stat_r <= o_stat_nxt;
    o_dv_r <= o_dv_nxt;
    o_dx_r <= o_dx_nxt;
    o_dy_r <= o_dy_nxt;
    o_dc_r <= o_dc_nxt;
  end

  assign out_valid       = ov_r;
  assign out_read_word   = o_read_r;
  assign out_status_word = o_stat_r;
  assign out_draw_valid  = o_dv_r;
  assign out_draw_x      = o_dx_r;
  assign out_draw_y      = o_dy_r;
  assign out_draw_color  = o_dc_r;

endmodule
`default_nettype wire

/* hdl/gcp_checker.sv */
// gcp_checker: port-level assertions for the gpu command port
`timescale 1ns / 1ps
`default_nettype none
module gcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_word,
  input wire logic [31:0] out_status_word,
  input wire logic        out_draw_valid,
  input wire logic [15:0] out_draw_x,
  input wire logic [15:0] out_draw_y,
  input wire logic [23:0] out_draw_color
);

  // ready and readout are never set together
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_status_word[26] && out_status_word[27]))
    else $error("ready and readout both set");

  // a draw request always hands the port back as ready
  a_draw_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_draw_valid) |-> out_status_word[26])
    else $error("draw issued without ready");

  // no draw means zero draw fields
  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_draw_valid) |->
      (out_draw_x == 16'd0 && out_draw_y == 16'd0 && out_draw_color == 24'd0))
    else $error("draw fields not cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_word)
      && $stable(out_status_word)))
    else $error("stalled item changed");

  // a stalled result blocks any new item
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && in_valid) |-> in_stall)
    else $error("item taken while result stalled");

endmodule

bind gpu_command_port_vram_transfer gcp_checker u_gcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_word   (out_read_word),
  .out_status_word (out_status_word),
  .out_draw_valid  (out_draw_valid),
  .out_draw_x      (out_draw_x),
  .out_draw_y      (out_draw_y),
  .out_draw_color  (out_draw_color)
);
`default_nettype wire
